/* rtl/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg
// Types and constants shared by the keyboard matrix debounce and modifier
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

  localparam int unsigned CountWidth = 4;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned AddrWidth  = 4;

  localparam logic [CountWidth-1:0] CountMax = 4'd15;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SHIFT  = 2'd1,
    MODE_CTRL   = 2'd2,
    MODE_THIRD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SHIFT_KEY = 2'd1,
    REG_CTRL_KEY  = 2'd2,
    REG_THIRD_KEY = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [1:0]           column;
    logic [3:0]           row;
    logic                 raw_pressed;
    logic [CodeWidth-1:0] base_code;
    logic [CodeWidth-1:0] shift_map_code;
    logic [CodeWidth-1:0] ctrl_map_code;
    logic [CodeWidth-1:0] third_map_code;
  } in_t;

  typedef struct packed {
    logic                 key_valid;
    logic [CodeWidth-1:0] key_code;
    logic                 pressed_now;
    logic [1:0]           active_mode;
  } out_t;

  typedef struct packed {
    logic [CountWidth-1:0] agree_count;
    logic                  last_reading;
    logic                  debounced;
    logic                  reported;
  } entry_t;

  typedef struct packed {
    logic [CountWidth-1:0] debounce_threshold;
    logic [CodeWidth-1:0]  shift_key_code;
    logic [CodeWidth-1:0]  ctrl_key_code;
    logic [CodeWidth-1:0]  third_key_code;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/kmd_ram.sv */
// ----------------------------------------------------------------------------
// kmd_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/kmd_regs.sv */
// ----------------------------------------------------------------------------
// kmd_regs
// APB-style configuration registers: debounce threshold and the three
// modifier key codes.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kmd_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [kmd_pkg::DataWidth-1:0]  pwdata,
  output logic      [kmd_pkg::DataWidth-1:0]  prdata,
  output logic                                pready,
  output kmd_pkg::cfg_t                       cfg_o
);

  kmd_pkg::cfg_t      cfg_q, cfg_d;
  kmd_pkg::reg_index_e index;
  logic               wr_en;

  assign index = kmd_pkg::reg_index_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (index)
        kmd_pkg::REG_THRESHOLD: cfg_d.debounce_threshold = pwdata[kmd_pkg::CountWidth-1:0];
        kmd_pkg::REG_SHIFT_KEY: cfg_d.shift_key_code = pwdata[kmd_pkg::CodeWidth-1:0];
        kmd_pkg::REG_CTRL_KEY:  cfg_d.ctrl_key_code = pwdata[kmd_pkg::CodeWidth-1:0];
        kmd_pkg::REG_THIRD_KEY: cfg_d.third_key_code = pwdata[kmd_pkg::CodeWidth-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (index)
      kmd_pkg::REG_THRESHOLD: prdata = kmd_pkg::DataWidth'(cfg_q.debounce_threshold);
      kmd_pkg::REG_SHIFT_KEY: prdata = kmd_pkg::DataWidth'(cfg_q.shift_key_code);
      kmd_pkg::REG_CTRL_KEY:  prdata = kmd_pkg::DataWidth'(cfg_q.ctrl_key_code);
      kmd_pkg::REG_THIRD_KEY: prdata = kmd_pkg::DataWidth'(cfg_q.third_key_code);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_threshold <= 4'd3;
      cfg_q.shift_key_code     <= '0;
      cfg_q.ctrl_key_code      <= '0;
      cfg_q.third_key_code     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/kmd_update.sv */
// ----------------------------------------------------------------------------
// kmd_update
// Read-modify-write logic for one key entry: debounce counter, change
// detection, modifier mode selection and keymap code selection.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_update (
  input  wire kmd_pkg::entry_t entry_i,
  input  wire kmd_pkg::in_t    item_i,
  input  wire logic            in_range_i,
  input  wire kmd_pkg::cfg_t   cfg_i,
  input  wire kmd_pkg::mode_e  mode_i,
  output kmd_pkg::entry_t      entry_o,
  output kmd_pkg::mode_e       mode_o,
  output kmd_pkg::out_t        result_o
);

  logic [kmd_pkg::CountWidth-1:0] count_inc;
  logic [kmd_pkg::CodeWidth-1:0]  mapped;
  logic                           is_mod;

  assign is_mod = (item_i.base_code == cfg_i.shift_key_code) ||
                  (item_i.base_code == cfg_i.ctrl_key_code) ||
                  (item_i.base_code == cfg_i.third_key_code);

  assign count_inc = (entry_i.agree_count < kmd_pkg::CountMax) ?
                     entry_i.agree_count + 4'd1 : entry_i.agree_count;

  always_comb begin
    case (mode_i)
      kmd_pkg::MODE_SHIFT: mapped = item_i.shift_map_code;
      kmd_pkg::MODE_CTRL:  mapped = item_i.ctrl_map_code;
      kmd_pkg::MODE_THIRD: mapped = item_i.third_map_code;
      default:             mapped = item_i.base_code;
    endcase
  end

  always_comb begin
    entry_o = entry_i;
    mode_o = mode_i;
    result_o.key_valid = 1'b0;
    result_o.key_code = '0;
    result_o.pressed_now = 1'b0;

    if (in_range_i) begin
      if (item_i.raw_pressed == entry_i.last_reading) begin
        entry_o.agree_count = count_inc;
        if (count_inc >= cfg_i.debounce_threshold) begin
          entry_o.debounced = item_i.raw_pressed;
          entry_o.agree_count = cfg_i.debounce_threshold;
        end
      end else begin
        entry_o.agree_count = '0;
      end
      entry_o.last_reading = item_i.raw_pressed;

      if (entry_o.debounced != entry_i.reported) begin
        if (entry_o.debounced) begin
          if ((mode_i == kmd_pkg::MODE_NORMAL) && is_mod) begin
            if (item_i.base_code == cfg_i.shift_key_code) begin
              mode_o = kmd_pkg::MODE_SHIFT;
            end else if (item_i.base_code == cfg_i.ctrl_key_code) begin
              mode_o = kmd_pkg::MODE_CTRL;
            end else begin
              mode_o = kmd_pkg::MODE_THIRD;
            end
          end else if (mapped != '0) begin
            result_o.key_valid = 1'b1;
            result_o.key_code = mapped;
          end
        end else if (is_mod) begin
          mode_o = kmd_pkg::MODE_NORMAL;
        end
        entry_o.reported = entry_o.debounced;
      end
      result_o.pressed_now = entry_o.debounced;
    end

    result_o.active_mode = mode_o;
  end

endmodule

`default_nettype wire

/* rtl/keyboard_matrix_debounce_modifier.sv */
// ----------------------------------------------------------------------------
// keyboard_matrix_debounce_modifier
// Per-key debounce and modifier-mode keymap selection over a key state RAM.
// A sample is registered in stage 1, then its result in the output register;
// one sample is taken every cycle while the output is not stalled.
// The key state RAM is read in the first stage and written back in the
// second, with forwarding of the last write-back.
// Reset initialises the configuration, the mode and one valid bit per key at
// once; there is no clearing pass, so samples are taken from the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_matrix_debounce_modifier #(
  parameter int unsigned COLUMNS = 4,
  parameter int unsigned ROWS    = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire kmd_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output kmd_pkg::out_t                       out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kmd_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [kmd_pkg::DataWidth-1:0]  pwdata,
  output logic      [kmd_pkg::DataWidth-1:0]  prdata,
  output logic                                pready
);

  localparam int unsigned Depth = COLUMNS * ROWS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EW = $bits(kmd_pkg::entry_t);

  kmd_pkg::cfg_t   cfg;
  kmd_pkg::entry_t rd_entry, cur_entry, new_entry;
  kmd_pkg::out_t   result;
  kmd_pkg::mode_e  mode_q, mode_d;

  logic [EW-1:0] rdata;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic          in_accept;
  logic          s1_adv;
  logic          s1_write;

  logic          s1_valid_q, s1_valid_d;
  kmd_pkg::in_t  s1_data_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_range_q;

  logic            wb_valid_q, wb_valid_d;
  logic [AW-1:0]   wb_addr_q;
  kmd_pkg::entry_t wb_entry_q;

  logic [Depth-1:0] entry_valid_q, entry_valid_d;

  logic          out_valid_q, out_valid_d;
  kmd_pkg::out_t out_data_q;

  kmd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_range = (32'(in_data_i.column) < COLUMNS) && (32'(in_data_i.row) < ROWS);
  assign in_addr = AW'(32'(in_data_i.column) * ROWS + 32'(in_data_i.row));

  assign s1_adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept = in_valid_i && !in_stall_o;
  assign s1_write = s1_valid_q && s1_adv && s1_range_q;

  kmd_ram #(
    .Width (EW),
    .Depth (Depth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (new_entry),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  assign rd_entry = kmd_pkg::entry_t'(rdata);

  always_comb begin
    if (wb_valid_q && (wb_addr_q == s1_addr_q)) begin
      cur_entry = wb_entry_q;
    end else if (entry_valid_q[s1_addr_q]) begin
      cur_entry = rd_entry;
    end else begin
      cur_entry = '0;
    end
  end

  kmd_update u_update (
    .entry_i    (cur_entry),
    .item_i     (s1_data_q),
    .in_range_i (s1_range_q),
    .cfg_i      (cfg),
    .mode_i     (mode_q),
    .entry_o    (new_entry),
    .mode_o     (mode_d),
    .result_o   (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    wb_valid_d = wb_valid_q || s1_write;

    entry_valid_d = entry_valid_q;
    if (s1_write) begin
      entry_valid_d[s1_addr_q] = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      wb_valid_q    <= 1'b0;
      entry_valid_q <= '0;
      out_valid_q   <= 1'b0;
      mode_q        <= kmd_pkg::MODE_NORMAL;
    end else begin
      s1_valid_q    <= s1_valid_d;
      wb_valid_q    <= wb_valid_d;
      entry_valid_q <= entry_valid_d;
      out_valid_q   <= out_valid_d;
      if (s1_valid_q && s1_adv) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q  <= in_data_i;
      s1_addr_q  <= in_addr;
      s1_range_q <= in_range;
    end
    if (s1_write) begin
      wb_addr_q  <= s1_addr_q;
      wb_entry_q <= new_entry;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

`default_nettype wire
